>>> hw/rtl/tlni_pkg.sv
package tlni_pkg;

	localparam int MAX_SIDE   = 256;
	localparam int SITE_W     = 16;
	localparam int LINK_W     = 18;
	localparam int SIDE_W     = 9;
	// The row is below the height, which never exceeds MAX_SIDE.
	localparam int ROW_W      = $clog2(MAX_SIDE);
	localparam int AREA_W     = 2 * SIDE_W;
	localparam int PROD_W     = ROW_W + SIDE_W;
	localparam int QDEPTH     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int OUT_BITS   = 6 * SITE_W + 6 * LINK_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
	} lat_cfg_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (int'(v) > MAX_SIDE) begin
			r = SIDE_W'(MAX_SIDE);
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/tlni_front.sv
module tlni_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tlni_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tlni_pkg::SIDE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tlni_pkg::SITE_W-1:0]     in_site,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [tlni_pkg::SITE_W-1:0]     push_site,
	output tlni_pkg::lat_cfg_t              cfg
);
	import tlni_pkg::*;

	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [AREA_W-1:0] area;
	logic              valid_s1;
	logic              keep_s1;
	logic [SITE_W-1:0] site_s1;
	logic              drain;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
		end else begin
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_idx))
					REG_WIDTH:  width_q  <= clamp_side(cfg_data);
					REG_HEIGHT: height_q <= clamp_side(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// An empty lattice gives a zero area, so every site is dropped.
	assign area = AREA_W'(width_q) * AREA_W'(height_q);

	// Sites outside the lattice are dropped here and never reach the queue.
	assign drain    = valid_s1 && (!keep_s1 || push_ready);
	assign in_ready = !valid_s1 || drain;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			site_s1 <= in_site;
			keep_s1 <= AREA_W'(in_site) < area;
		end
	end

	assign push_valid = valid_s1 && keep_s1;
	assign push_site  = site_s1;
	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule

>>> hw/rtl/tlni_queue.sv
module tlni_queue #(
	parameter int DEPTH = tlni_pkg::QDEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_valid,
	output logic                        push_ready,
	input  logic [tlni_pkg::SITE_W-1:0] push_site,
	output logic                        pop_valid,
	input  logic                        pop_ready,
	output logic [tlni_pkg::SITE_W-1:0] pop_site
);
	import tlni_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [SITE_W-1:0] mem [0:DEPTH-1];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_site   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_site;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue fill count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("queue fill count missed a pop");

endmodule

>>> hw/rtl/tlni_back.sv
module tlni_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlni_pkg::lat_cfg_t              cfg,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  logic [tlni_pkg::SITE_W-1:0]     pop_site,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tlni_pkg::OUT_DATA_W-1:0] out_data
);
	import tlni_pkg::*;

	logic en;

	// Divider pipeline, one quotient bit per stage; index k is the stage.
	logic              dv_valid_sk [0:ROW_W];
	logic [SITE_W-1:0] dv_site_sk  [0:ROW_W];
	logic [SIDE_W-1:0] dv_rem_sk   [0:ROW_W];
	logic [ROW_W-1:0]  dv_quo_sk   [0:ROW_W];

	logic              valid_s1, valid_s2, valid_s3;
	logic [SITE_W-1:0] site_s1, site_s2;
	logic [SIDE_W-1:0] col_s1, col_r_s1, col_l_s1;
	logic [SITE_W-1:0] base_s1;
	logic [SITE_W-1:0] up_s1, down_s1;
	logic [SITE_W-1:0] right_s2, left_s2, tr_s2, bl_s2, tl_s2, br_s2;
	logic [SITE_W-1:0] right_s3, left_s3, tr_s3, bl_s3, tl_s3, br_s3;
	logic [LINK_W-1:0] rl_s3, ll_s3, trl_s3, bll_s3, tll_s3, brl_s3;

	logic [SIDE_W-1:0] col;
	logic [ROW_W-1:0]  row;
	logic [SIDE_W-1:0] col_r, col_l;
	logic [ROW_W-1:0]  row_u, row_d;

	// The whole back end advances together whenever the output stage is free.
	assign en        = !valid_s3 || out_ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid_sk[0] <= 1'b0;
		end else if (en) begin
			dv_valid_sk[0] <= pop_valid;
		end
	end

	// The site is below width times 2**ROW_W, so its upper bits are already
	// a valid partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			dv_site_sk[0] <= pop_site;
			dv_rem_sk[0]  <= SIDE_W'(pop_site >> ROW_W);
			dv_quo_sk[0]  <= '0;
		end
	end

	for (genvar k = 0; k < ROW_W; k++) begin : g_div
		logic [SIDE_W:0] trial;
		logic [SIDE_W:0] diff;
		logic            ge;

		assign trial = {dv_rem_sk[k], dv_site_sk[k][ROW_W-1-k]};
		assign ge    = trial >= {1'b0, cfg.width};
		assign diff  = trial - {1'b0, cfg.width};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				dv_valid_sk[k+1] <= dv_valid_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_site_sk[k+1] <= dv_site_sk[k];
				dv_rem_sk[k+1]  <= ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
				dv_quo_sk[k+1]  <= {dv_quo_sk[k][ROW_W-2:0], ge};
			end
		end
	end

	assign col = dv_rem_sk[ROW_W];
	assign row = dv_quo_sk[ROW_W];

	always_comb begin
		col_r = col + SIDE_W'(1);
		if (col_r == cfg.width) begin
			col_r = '0;
		end
		col_l = (col == '0) ? cfg.width - SIDE_W'(1) : col - SIDE_W'(1);
		row_u = row + ROW_W'(1);
		if ({1'b0, row} + SIDE_W'(1) == cfg.height) begin
			row_u = '0;
		end
		row_d = (row == '0) ? ROW_W'(cfg.height - SIDE_W'(1)) : row - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= dv_valid_sk[ROW_W];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			site_s1  <= dv_site_sk[ROW_W];
			col_s1   <= col;
			col_r_s1 <= col_r;
			col_l_s1 <= col_l;
			// row times width is the site with its column removed.
			base_s1  <= dv_site_sk[ROW_W] - SITE_W'(col);
			up_s1    <= SITE_W'(PROD_W'(row_u) * PROD_W'(cfg.width));
			down_s1  <= SITE_W'(PROD_W'(row_d) * PROD_W'(cfg.width));

			site_s2  <= site_s1;
			right_s2 <= base_s1 + SITE_W'(col_r_s1);
			left_s2  <= base_s1 + SITE_W'(col_l_s1);
			tr_s2    <= up_s1 + SITE_W'(col_s1);
			bl_s2    <= down_s1 + SITE_W'(col_s1);
			tl_s2    <= up_s1 + SITE_W'(col_l_s1);
			br_s2    <= down_s1 + SITE_W'(col_r_s1);

			right_s3 <= right_s2;
			left_s3  <= left_s2;
			tr_s3    <= tr_s2;
			bl_s3    <= bl_s2;
			tl_s3    <= tl_s2;
			br_s3    <= br_s2;
			rl_s3    <= {1'b0, site_s2, 1'b0} + LINK_W'(site_s2);
			ll_s3    <= {1'b0, left_s2, 1'b0} + LINK_W'(left_s2);
			trl_s3   <= {1'b0, site_s2, 1'b0} + LINK_W'(site_s2) + LINK_W'(1);
			bll_s3   <= {1'b0, bl_s2, 1'b0} + LINK_W'(bl_s2) + LINK_W'(1);
			tll_s3   <= {1'b0, site_s2, 1'b0} + LINK_W'(site_s2) + LINK_W'(2);
			brl_s3   <= {1'b0, br_s2, 1'b0} + LINK_W'(br_s2) + LINK_W'(2);
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
		brl_s3, tll_s3, bll_s3, trl_s3, ll_s3, rl_s3,
		br_s3, tl_s3, bl_s3, tr_s3, left_s3, right_s3};

endmodule

>>> hw/rtl/triangular_lattice_neighbour_index_top.sv
// Neighbour lookup for a periodic parallelogram triangular lattice. Each site
// index transferred in gives one result with the six wrapped neighbour sites
// and the six links touching the site; a site at or beyond width times height
// gives no result. Width and height are written through the cfg port while
// the block is idle (the block does not enforce this) and are clamped to 256.
// The block sustains one site per cycle unless the output stalls; an 8-stage
// pipelined divider splits the site into row and column before the neighbour
// and link stages. A four-entry queue between the range check and the
// divider lets input transfers continue while a result waits on the output.
module triangular_lattice_neighbour_index_top #(
	parameter int QUEUE_DEPTH = tlni_pkg::QDEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tlni_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tlni_pkg::SIDE_W-1:0]     cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] site_index
	input  logic [tlni_pkg::SITE_W-1:0]     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// right_site, left_site, top_right_site, bottom_left_site, top_left_site,
	// bottom_right_site (16 bits each), then right_link, left_link,
	// top_right_link, bottom_left_link, top_left_link, bottom_right_link
	// (18 bits each), lowest bits first, zero padded at the top
	output logic [tlni_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tlni_pkg::*;

	lat_cfg_t          cfg;
	logic              push_valid;
	logic              push_ready;
	logic [SITE_W-1:0] push_site;
	logic              pop_valid;
	logic              pop_ready;
	logic [SITE_W-1:0] pop_site;

	tlni_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_site    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_site  (push_site),
		.cfg        (cfg)
	);

	tlni_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_site  (push_site),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_site   (pop_site)
	);

	tlni_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_site  (pop_site),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
